// File: hdl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared widths and types for the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int AVG_W          = 24;
  localparam int CFG_W          = 9;
  localparam int FRAC_W         = 8;
  localparam int MAX_WINDOW_DEF = 256;

  // one accepted item, toward the sample ring
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       series_start;
  } ring_req_t;

  // ring answer, registered in the cycle after the request
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic                       full;   // oldest sample leaves the window
    logic                       clear;  // new series, sum restarts at zero
    logic                       emit;   // window full after this item
  } ring_resp_t;

endpackage

// File: hdl/swa_ifs.sv
// ----------------------------------------------------------------------------
// swa_in_if / swa_out_if
// Valid/ready channels for samples in and averages out.
// ----------------------------------------------------------------------------
interface swa_in_if;
  import swa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       series_start;

  modport source (output valid, output sample, output series_start, input ready);
  modport sink   (input valid, input sample, input series_start, output ready);
endinterface

interface swa_out_if;
  import swa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// File: hdl/swa_ring.sv
// ----------------------------------------------------------------------------
// swa_ring
// Sample ring memory with write position and fill count.
// ----------------------------------------------------------------------------
module swa_ring #(
  parameter int MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF,
  parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic [WIN_W-1:0]       win,
  input  swa_pkg::ring_req_t     req,
  output swa_pkg::ring_resp_t    resp
);
  import swa_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);

  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [WIN_W-1:0]    fill;
  logic [AW-1:0]       pos;

  logic [WIN_W-1:0]    fill_cur;
  logic [WIN_W-1:0]    fill_next;
  logic [AW-1:0]       pos_cur;
  logic [WIN_W-1:0]    pos_inc;
  logic [AW-1:0]       pos_next;

  always_comb begin
    fill_cur = req.series_start ? '0 : ((fill > win) ? win : fill);
    pos_cur  = (req.series_start || (WIN_W'(pos) >= win)) ? '0 : pos;
    pos_inc  = WIN_W'(pos_cur) + 1'b1;
    pos_next = (pos_inc >= win) ? '0 : pos_inc[AW-1:0];
    fill_next = (fill_cur < win) ? fill_cur + 1'b1 : fill_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pos  <= '0;
    end else if (clear) begin
      fill <= '0;
      pos  <= '0;
    end else if (req.valid) begin
      fill <= fill_next;
      pos  <= pos_next;
    end
  end

  // read-before-write: old entry comes out as the new one goes in
  always_ff @(posedge clk) begin
    if (req.valid) begin
      resp.old_sample <= mem[pos_cur];
      mem[pos_cur]    <= req.sample;
      resp.sample     <= req.sample;
      resp.full       <= (fill_cur == win);
      resp.clear      <= req.series_start;
      resp.emit       <= (fill_next == win);
    end
  end

endmodule

// File: hdl/swa_acc.sv
// ----------------------------------------------------------------------------
// swa_acc
// Bit-serial running sum update: sum + new - old, plus serial negation.
// ----------------------------------------------------------------------------
module swa_acc #(
  parameter int SUM_W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                start,
  input  swa_pkg::ring_resp_t cmd,
  output logic                done,
  output logic                sign,
  output logic [SUM_W-1:0]    mag
);
  import swa_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] sum_sr;
  logic [SUM_W-1:0] neg_sr;
  logic [SUM_W-1:0] a_sr;
  logic [SUM_W-1:0] b_sr;
  logic             c_add;
  logic             c_sub;
  logic             c_neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  logic s0, r, ng;
  logic c_add_next, c_sub_next, c_neg_next;

  always_comb begin
    s0         = sum_sr[0] ^ a_sr[0] ^ c_add;
    c_add_next = (sum_sr[0] & a_sr[0]) | (c_add & (sum_sr[0] ^ a_sr[0]));
    r          = s0 ^ b_sr[0] ^ c_sub;
    c_sub_next = (s0 & b_sr[0]) | (c_sub & (s0 ^ b_sr[0]));
    ng         = ~r ^ c_neg;
    c_neg_next = ~r & c_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
      sum_sr <= '0;
    end else begin
      done <= 1'b0;
      if (clear) begin
        sum_sr <= '0;
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
        if (cmd.clear) begin
          sum_sr <= '0;
        end
      end else if (busy) begin
        sum_sr <= {r, sum_sr[SUM_W-1:1]};
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // subtract the old sample as ~old + 1 when the window was already full
  always_ff @(posedge clk) begin
    if (start) begin
      a_sr  <= {{(SUM_W-SAMPLE_W){cmd.sample[SAMPLE_W-1]}}, cmd.sample};
      b_sr  <= cmd.full ? ~{{(SUM_W-SAMPLE_W){cmd.old_sample[SAMPLE_W-1]}}, cmd.old_sample}
                        : '0;
      c_add <= 1'b0;
      c_sub <= cmd.full;
      c_neg <= 1'b1;
    end else if (busy) begin
      a_sr   <= {1'b0, a_sr[SUM_W-1:1]};
      b_sr   <= {1'b0, b_sr[SUM_W-1:1]};
      neg_sr <= {ng, neg_sr[SUM_W-1:1]};
      c_add  <= c_add_next;
      c_sub  <= c_sub_next;
      c_neg  <= c_neg_next;
    end
  end

  assign sign = sum_sr[SUM_W-1];
  assign mag  = sign ? neg_sr : sum_sr;

endmodule

// File: hdl/swa_div.sv
// ----------------------------------------------------------------------------
// swa_div
// Restoring divider, one quotient bit per cycle; sign applied at the end.
// ----------------------------------------------------------------------------
module swa_div #(
  parameter int SUM_W = 24,
  parameter int WIN_W = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             sign,
  input  logic [SUM_W-1:0]                 mag,
  input  logic [WIN_W-1:0]                 win,
  output logic                             done,
  output logic signed [swa_pkg::AVG_W-1:0] average
);
  import swa_pkg::*;

  localparam int DV_W  = SUM_W + FRAC_W;
  localparam int CNT_W = $clog2(DV_W + 1);

  logic [DV_W-1:0]  dv;
  logic [WIN_W-1:0] rem;
  logic             sgn;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  logic [WIN_W:0]   trial;
  logic [WIN_W:0]   diff;
  logic             take;
  logic [AVG_W-1:0] q;

  always_comb begin
    trial = {rem, dv[DV_W-1]};
    diff  = trial - {1'b0, win};
    take  = (trial >= {1'b0, win});
    q     = dv[AVG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= {mag, {FRAC_W{1'b0}}};
      rem <= '0;
      sgn <= sign;
    end else if (busy) begin
      dv  <= {dv[DV_W-2:0], take};
      rem <= take ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    end
  end

  assign average = sgn ? (~q + 1'b1) : q;

endmodule

// File: hdl/sliding_window_average.sv
// From accept, an item passes the ring read, the bit-serial sum update and, if it completes
// a window, the bit-serial divide and the output register. The input is ready only when idle,
// so it takes no new item before the last is through; a held average stalls the input.
// Adder width SUM_W, divider dividend SUM_W + 8; SUM_W = 16 + clog2(MAX_WINDOW).
// Reset (synchronous): window_length = 1, running sum, fill count and position zero.
// The sample ring is not cleared; entries are used only after being written.
// ----------------------------------------------------------------------------
// sliding_window_average
// Streaming simple moving average with 8 fraction bits, digit-serial datapath.
// ----------------------------------------------------------------------------
module sliding_window_average #(
  parameter int MAX_WINDOW = swa_pkg::MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       window_length_we,
  input  logic [swa_pkg::CFG_W-1:0]  window_length,
  swa_in_if.sink                     din,
  swa_out_if.source                  dout
);
  import swa_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [CFG_W-1:0]        wl;
  logic [WIN_W-1:0]        win;
  ring_req_t               req;
  ring_resp_t              resp;
  logic                    acc_done;
  logic                    sum_sign;
  logic [SUM_W-1:0]        sum_mag;
  logic                    div_start;
  logic                    div_done;
  logic signed [AVG_W-1:0] div_avg;
  logic                    out_valid;
  logic signed [AVG_W-1:0] out_avg;
  logic                    load;

  always_ff @(posedge clk) begin
    if (rst) begin
      wl <= CFG_W'(1);
    end else if (window_length_we) begin
      wl <= window_length;
    end
  end

  always_comb begin
    if (wl == '0) begin
      win = WIN_W'(1);
    end else if (32'(wl) > 32'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(wl);
    end
  end

  assign din.ready        = (state == S_IDLE);
  assign req.valid        = din.valid && din.ready;
  assign req.sample       = din.sample;
  assign req.series_start = din.series_start;

  swa_ring #(
    .MAX_WINDOW (MAX_WINDOW),
    .WIN_W      (WIN_W)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .clear (window_length_we),
    .win   (win),
    .req   (req),
    .resp  (resp)
  );

  swa_acc #(
    .SUM_W (SUM_W)
  ) u_acc (
    .clk   (clk),
    .rst   (rst),
    .clear (window_length_we),
    .start (state == S_READ),
    .cmd   (resp),
    .done  (acc_done),
    .sign  (sum_sign),
    .mag   (sum_mag)
  );

  assign div_start = (state == S_ACC) && acc_done && resp.emit;

  swa_div #(
    .SUM_W (SUM_W),
    .WIN_W (WIN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .sign    (sum_sign),
    .mag     (sum_mag),
    .win     (win),
    .done    (div_done),
    .average (div_avg)
  );

  assign load = (state == S_PUT) && (!out_valid || dout.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) state_next = S_READ;
      S_READ: state_next = S_ACC;
      S_ACC: begin
        if (acc_done) begin
          state_next = resp.emit ? S_DIV : S_IDLE;
        end
      end
      S_DIV: if (div_done) state_next = S_PUT;
      S_PUT: if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_avg <= div_avg;
    end
  end

  assign dout.valid   = out_valid;
  assign dout.average = out_avg;

`ifndef SYNTH
  a_put_from_div : assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(state) == S_PUT)
    else $error("average raised outside the output state");

  a_div_done_state : assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished while not awaited");

  a_acc_done_state : assert property (@(posedge clk) disable iff (rst)
    acc_done |-> state == S_ACC)
    else $error("accumulator finished while not awaited");
`endif

endmodule
